// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is held
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

// ----- rtl/cshb_pkg.sv -----
package cshb_pkg;

  // channel count and delay indexing
  localparam int CHANNELS = 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // data widths
  localparam int SAMPLE_W = 24;
  localparam int DELAY_W  = 32;
  localparam int NUM_W    = 21;
  localparam int DEN_W    = 24;
  localparam int NUM_FRAC = 17;
  localparam int DEN_FRAC = 22;
  localparam int COEF_W   = DEN_W;
  localparam int PROD_W   = DELAY_W + COEF_W;
  // three floored numerator products of up to 35 bits each, plus sign
  localparam int ACC_W    = 38;

  // coefficient registers
  localparam int NUM_REG_W  = 3 * NUM_W;
  localparam int DEN_REG_W  = 2 * DEN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  // b0 = 1.0, b1 = b2 = 0
  localparam logic [NUM_REG_W-1:0] NUM_RESET = NUM_REG_W'(1) << NUM_FRAC;
  localparam logic [DEN_REG_W-1:0] DEN_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_NUM  = 3'd0,
    REG_LOW_DEN  = 3'd1,
    REG_HIGH_NUM = 3'd2,
    REG_HIGH_DEN = 3'd3
  } cfg_reg_e;

  // operand selects of the shared multiplier
  typedef enum logic [2:0] {
    COEF_A1 = 3'd0,
    COEF_A2 = 3'd1,
    COEF_B0 = 3'd2,
    COEF_B1 = 3'd3,
    COEF_B2 = 3'd4
  } coef_sel_e;

  typedef enum logic [1:0] {
    DATA_W1  = 2'd0,
    DATA_W2  = 2'd1,
    DATA_NEW = 2'd2
  } data_sel_e;

  // accumulator operations
  typedef enum logic [2:0] {
    ACC_HOLD     = 3'd0,
    ACC_LOAD_X   = 3'd1,
    ACC_SUB_DEN  = 3'd2,
    ACC_LOAD_NUM = 3'd3,
    ACC_ADD_NUM  = 3'd4
  } acc_op_e;

  // sequencer to datapath controls
  typedef struct packed {
    logic      mul_en;
    coef_sel_e coef_sel;
    data_sel_e data_sel;
    acc_op_e   acc_op;
    logic      w_load;
    logic      stage_hi;
    logic      stage_end;
  } cshb_ctrl_t;

  typedef struct packed {
    logic                       chan_in;
    logic signed [SAMPLE_W-1:0] sample_in;
  } cshb_in_t;

  typedef struct packed {
    logic                       chan_out;
    logic signed [SAMPLE_W-1:0] sample_out;
  } cshb_out_t;

endpackage

// ----- rtl/cascaded_shelf_biquad.sv -----
// Two shelving biquads in cascade (low shelf, then high shelf), direct form II,
// with two 32-bit delay words per stage for each channel. One item is taken at
// a time: a single 32x24 multiplier with a product register and one accumulator
// do the five products of each biquad in turn, so the result is offered once
// the high shelf finishes and the next item is accepted only after that. A
// result that is not taken holds the last step until the output register frees.
// Coefficients sit in four registers written over the config port while the
// block is idle, a rule the user must keep; the block does not enforce it. b0,
// b1, b2 are signed Q4.17 fields and a1, a2 signed Q2.22 fields, lowest first.
// Channels at or above the configured channel count pass through unchanged.
`include "assert_macros.svh"

module cascaded_shelf_biquad (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cshb_pkg::cshb_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cshb_pkg::cshb_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cshb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cshb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cshb_pkg::cshb_ctrl_t ctrl;

  logic [cshb_pkg::NUM_REG_W-1:0] low_num_q, high_num_q;
  logic [cshb_pkg::DEN_REG_W-1:0] low_den_q, high_den_q;

  logic signed [cshb_pkg::DELAY_W-1:0] low_d1_q  [cshb_pkg::CHANNELS];
  logic signed [cshb_pkg::DELAY_W-1:0] low_d2_q  [cshb_pkg::CHANNELS];
  logic signed [cshb_pkg::DELAY_W-1:0] high_d1_q [cshb_pkg::CHANNELS];
  logic signed [cshb_pkg::DELAY_W-1:0] high_d2_q [cshb_pkg::CHANNELS];

  logic                                 chan_q;
  logic                                 active_q;
  logic signed [cshb_pkg::SAMPLE_W-1:0] x_q;
  logic [cshb_pkg::CH_IDX_W-1:0]        idx;
  logic signed [cshb_pkg::DELAY_W-1:0]  w1, w2, w_new;
  logic signed [cshb_pkg::SAMPLE_W-1:0] y;
  logic [cshb_pkg::NUM_REG_W-1:0]       num;
  logic [cshb_pkg::DEN_REG_W-1:0]       den;
  logic                                 in_fire;
  logic                                 out_valid_q;
  cshb_pkg::cshb_out_t                  out_data_q;

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_num_q  <= cshb_pkg::NUM_RESET;
      low_den_q  <= cshb_pkg::DEN_RESET;
      high_num_q <= cshb_pkg::NUM_RESET;
      high_den_q <= cshb_pkg::DEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cshb_pkg::cfg_reg_e'(cfg_index_i))
        cshb_pkg::REG_LOW_NUM:  low_num_q  <= cfg_data_i[cshb_pkg::NUM_REG_W-1:0];
        cshb_pkg::REG_LOW_DEN:  low_den_q  <= cfg_data_i[cshb_pkg::DEN_REG_W-1:0];
        cshb_pkg::REG_HIGH_NUM: high_num_q <= cfg_data_i[cshb_pkg::NUM_REG_W-1:0];
        cshb_pkg::REG_HIGH_DEN: high_den_q <= cfg_data_i[cshb_pkg::DEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture, stage input carried from the low shelf to the high shelf
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chan_q   <= in_data_i.chan_in;
      active_q <= 32'(in_data_i.chan_in) < cshb_pkg::CHANNELS;
      x_q      <= in_data_i.sample_in;
    end else if (ctrl.stage_end && !ctrl.stage_hi && active_q) begin
      x_q <= y;
    end
  end

  // per-stage operands
  assign idx = cshb_pkg::CH_IDX_W'(chan_q);
  assign num = ctrl.stage_hi ? high_num_q : low_num_q;
  assign den = ctrl.stage_hi ? high_den_q : low_den_q;
  assign w1  = ctrl.stage_hi ? high_d1_q[idx] : low_d1_q[idx];
  assign w2  = ctrl.stage_hi ? high_d2_q[idx] : low_d2_q[idx];

  // delay line update at the end of each stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < cshb_pkg::CHANNELS; c++) begin
        low_d1_q[c]  <= '0;
        low_d2_q[c]  <= '0;
        high_d1_q[c] <= '0;
        high_d2_q[c] <= '0;
      end
    end else if (ctrl.stage_end && active_q) begin
      if (ctrl.stage_hi) begin
        high_d2_q[idx] <= high_d1_q[idx];
        high_d1_q[idx] <= w_new;
      end else begin
        low_d2_q[idx] <= low_d1_q[idx];
        low_d1_q[idx] <= w_new;
      end
    end
  end

  cshb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_valid_q && !out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  cshb_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .num_i  (num),
    .den_i  (den),
    .w1_i   (w1),
    .w2_i   (w2),
    .x_i    (x_q),
    .w_o    (w_new),
    .y_o    (y)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.stage_end && ctrl.stage_hi) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.stage_end && ctrl.stage_hi) begin
      out_data_q.chan_out   <= chan_q;
      out_data_q.sample_out <= active_q ? y : x_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_AT(a_x_quiet, !ctrl.stage_end && !in_fire |=> $stable(x_q), "stage input moved outside a stage end or accept")
  `ASSERT_AT(a_result_shown, ctrl.stage_end && ctrl.stage_hi |=> out_valid_q, "finished item not offered")
  `ASSERT_NEVER(a_no_overwrite, ctrl.stage_end && ctrl.stage_hi && out_valid_q && !out_ready_i, "result overwritten before taken")

endmodule

// ----- rtl/cshb_mac.sv -----
module cshb_mac (
  input  logic                                 clk_i,
  input  cshb_pkg::cshb_ctrl_t                 ctrl_i,
  input  logic [cshb_pkg::NUM_REG_W-1:0]       num_i,
  input  logic [cshb_pkg::DEN_REG_W-1:0]       den_i,
  input  logic signed [cshb_pkg::DELAY_W-1:0]  w1_i,
  input  logic signed [cshb_pkg::DELAY_W-1:0]  w2_i,
  input  logic signed [cshb_pkg::SAMPLE_W-1:0] x_i,
  output logic signed [cshb_pkg::DELAY_W-1:0]  w_o,
  output logic signed [cshb_pkg::SAMPLE_W-1:0] y_o
);

  logic signed [cshb_pkg::COEF_W-1:0]  coef;
  logic signed [cshb_pkg::DELAY_W-1:0] data;
  logic signed [cshb_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic signed [cshb_pkg::PROD_W-1:0]  prod_den_sh, prod_num_sh;
  logic signed [cshb_pkg::ACC_W-1:0]   prod_den, prod_num;
  logic signed [cshb_pkg::ACC_W-1:0]   acc_d, acc_q;
  logic signed [cshb_pkg::DELAY_W-1:0] w_sat, w_q;
  logic [cshb_pkg::ACC_W-cshb_pkg::DELAY_W:0]  w_top;
  logic [cshb_pkg::ACC_W-cshb_pkg::SAMPLE_W:0] y_top;

  // coefficient select, numerator fields sign extended to the den width
  always_comb begin
    case (ctrl_i.coef_sel)
      cshb_pkg::COEF_A1: coef = $signed(den_i[cshb_pkg::DEN_W-1:0]);
      cshb_pkg::COEF_A2: coef = $signed(den_i[2*cshb_pkg::DEN_W-1:cshb_pkg::DEN_W]);
      cshb_pkg::COEF_B0: coef = $signed({{(cshb_pkg::COEF_W-cshb_pkg::NUM_W)
                                 {num_i[cshb_pkg::NUM_W-1]}}, num_i[cshb_pkg::NUM_W-1:0]});
      cshb_pkg::COEF_B1: coef = $signed({{(cshb_pkg::COEF_W-cshb_pkg::NUM_W)
                                 {num_i[2*cshb_pkg::NUM_W-1]}},
                                 num_i[2*cshb_pkg::NUM_W-1:cshb_pkg::NUM_W]});
      cshb_pkg::COEF_B2: coef = $signed({{(cshb_pkg::COEF_W-cshb_pkg::NUM_W)
                                 {num_i[3*cshb_pkg::NUM_W-1]}},
                                 num_i[3*cshb_pkg::NUM_W-1:2*cshb_pkg::NUM_W]});
      default:           coef = '0;
    endcase
  end

  // delay word select
  always_comb begin
    case (ctrl_i.data_sel)
      cshb_pkg::DATA_W1:  data = w1_i;
      cshb_pkg::DATA_W2:  data = w2_i;
      cshb_pkg::DATA_NEW: data = w_q;
      default:            data = '0;
    endcase
  end

  // shared multiplier, registered
  assign prod_d = coef * data;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // floored products, arithmetic shift rounds toward minus infinity
  assign prod_den_sh = prod_q >>> cshb_pkg::DEN_FRAC;
  assign prod_num_sh = prod_q >>> cshb_pkg::NUM_FRAC;
  assign prod_den    = $signed(prod_den_sh[cshb_pkg::ACC_W-1:0]);
  assign prod_num    = $signed(prod_num_sh[cshb_pkg::ACC_W-1:0]);

  // accumulator
  always_comb begin
    case (ctrl_i.acc_op)
      cshb_pkg::ACC_LOAD_X:   acc_d = cshb_pkg::ACC_W'(x_i);
      cshb_pkg::ACC_SUB_DEN:  acc_d = acc_q - prod_den;
      cshb_pkg::ACC_LOAD_NUM: acc_d = prod_num;
      cshb_pkg::ACC_ADD_NUM:  acc_d = acc_q + prod_num;
      default:                acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // saturate the new delay word to 32 bits
  assign w_top = acc_q[cshb_pkg::ACC_W-1:cshb_pkg::DELAY_W-1];
  always_comb begin
    if ((&w_top) || !(|w_top)) begin
      w_sat = acc_q[cshb_pkg::DELAY_W-1:0];
    end else if (acc_q[cshb_pkg::ACC_W-1]) begin
      w_sat = {1'b1, {(cshb_pkg::DELAY_W-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(cshb_pkg::DELAY_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.w_load) begin
      w_q <= w_sat;
    end
  end

  assign w_o = w_q;

  // saturate the stage output to 24 bits
  assign y_top = acc_q[cshb_pkg::ACC_W-1:cshb_pkg::SAMPLE_W-1];
  always_comb begin
    if ((&y_top) || !(|y_top)) begin
      y_o = acc_q[cshb_pkg::SAMPLE_W-1:0];
    end else if (acc_q[cshb_pkg::ACC_W-1]) begin
      y_o = {1'b1, {(cshb_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(cshb_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ----- rtl/cshb_seq.sv -----
`include "assert_macros.svh"

module cshb_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_stall_i,
  output logic                 in_ready_o,
  output cshb_pkg::cshb_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // eight steps per biquad, the multiply of one step overlaps the add of the last
  typedef enum logic [2:0] {
    STEP_MUL_A1 = 3'd0,
    STEP_MUL_A2 = 3'd1,
    STEP_SUB_A2 = 3'd2,
    STEP_LOAD_W = 3'd3,
    STEP_MUL_B2 = 3'd4,
    STEP_MUL_B0 = 3'd5,
    STEP_ADD_B0 = 3'd6,
    STEP_DONE   = 3'd7
  } step_e;

  state_e state_d, state_q;
  step_e  step_d, step_q;
  logic   stage_d, stage_q;
  logic   finish;

  assign in_ready_o = (state_q == ST_IDLE);
  // last step of a stage completes, except in the high shelf while the output register is full and not taken
  assign finish = (state_q == ST_RUN) && (step_q == STEP_DONE) && !(stage_q && out_stall_i);

  // step decode
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.coef_sel  = cshb_pkg::COEF_A1;
    ctrl_o.data_sel  = cshb_pkg::DATA_W1;
    ctrl_o.acc_op    = cshb_pkg::ACC_HOLD;
    ctrl_o.stage_hi  = stage_q;
    ctrl_o.stage_end = finish;
    if (state_q == ST_RUN) begin
      unique case (step_q)
        STEP_MUL_A1: begin
          ctrl_o.mul_en   = 1'b1;
          ctrl_o.coef_sel = cshb_pkg::COEF_A1;
          ctrl_o.data_sel = cshb_pkg::DATA_W1;
          ctrl_o.acc_op   = cshb_pkg::ACC_LOAD_X;
        end
        STEP_MUL_A2: begin
          ctrl_o.mul_en   = 1'b1;
          ctrl_o.coef_sel = cshb_pkg::COEF_A2;
          ctrl_o.data_sel = cshb_pkg::DATA_W2;
          ctrl_o.acc_op   = cshb_pkg::ACC_SUB_DEN;
        end
        STEP_SUB_A2: begin
          ctrl_o.acc_op = cshb_pkg::ACC_SUB_DEN;
        end
        STEP_LOAD_W: begin
          ctrl_o.mul_en   = 1'b1;
          ctrl_o.coef_sel = cshb_pkg::COEF_B1;
          ctrl_o.data_sel = cshb_pkg::DATA_W1;
          ctrl_o.w_load   = 1'b1;
        end
        STEP_MUL_B2: begin
          ctrl_o.mul_en   = 1'b1;
          ctrl_o.coef_sel = cshb_pkg::COEF_B2;
          ctrl_o.data_sel = cshb_pkg::DATA_W2;
          ctrl_o.acc_op   = cshb_pkg::ACC_LOAD_NUM;
        end
        STEP_MUL_B0: begin
          ctrl_o.mul_en   = 1'b1;
          ctrl_o.coef_sel = cshb_pkg::COEF_B0;
          ctrl_o.data_sel = cshb_pkg::DATA_NEW;
          ctrl_o.acc_op   = cshb_pkg::ACC_ADD_NUM;
        end
        STEP_ADD_B0: begin
          ctrl_o.acc_op = cshb_pkg::ACC_ADD_NUM;
        end
        default: begin
          ctrl_o.acc_op = cshb_pkg::ACC_HOLD;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    stage_d = stage_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = STEP_MUL_A1;
          stage_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_q != STEP_DONE) begin
          step_d = step_e'(step_q + 3'd1);
        end else if (!stage_q) begin
          step_d  = STEP_MUL_A1;
          stage_d = 1'b1;
        end else if (finish) begin
          state_d = ST_IDLE;
          step_d  = STEP_MUL_A1;
          stage_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = STEP_MUL_A1;
        stage_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_MUL_A1;
      stage_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      stage_q <= stage_d;
    end
  end

  `ASSERT_AT(a_idle_clean, state_q == ST_IDLE |-> step_q == STEP_MUL_A1 && !stage_q, "idle with step or stage not cleared")
  `ASSERT_AT(a_hold_on_stall, state_q == ST_RUN && step_q == STEP_DONE && stage_q && out_stall_i |=> state_q == ST_RUN && step_q == STEP_DONE && stage_q, "final step left while output register full")
  `ASSERT_AT(a_start_run, in_valid_i && in_ready_o |=> state_q == ST_RUN && step_q == STEP_MUL_A1 && !stage_q, "accepted item did not start the low shelf")

endmodule
